// File: rtl/core/size_class_block_allocator_macros.svh
// Assertion helpers used by the allocator RTL.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCBA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCBA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/scba_pkg.sv
`default_nettype none

package scba_pkg;

  localparam int SMALL_MAX       = 512;
  localparam int CLASS_COUNT     = 7;
  localparam int CLASS_W         = 3;
  localparam int ADDR_W          = 18;
  localparam int HEAD_W          = 19;
  localparam int SIZE_W          = 24;
  localparam int COPY_W          = 10;
  localparam int ADDR_SPACE      = 262144;
  localparam int LINK_DEPTH      = ADDR_SPACE / 8;
  localparam int LINK_AW         = 15;
  localparam int CHUNK_BYTES_DEF = 16 * 1024;
  localparam int CHUNK_COUNT_DEF = 16;

  localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(ADDR_SPACE);

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_RESIZE = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_KEPT  = 2'd1;
  localparam logic [1:0] STAT_LARGE = 2'd2;
  localparam logic [1:0] STAT_OOM   = 2'd3;

  typedef struct packed {
    logic               go;
    logic [CLASS_W-1:0] cls;
  } bump_cmd_t;

  typedef struct packed {
    logic              ok;
    logic [HEAD_W-1:0] addr;
  } bump_rsp_t;

  // Smallest class whose block holds the size (up to 512); zero lands in the 8-byte class.
  function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
    logic [CLASS_W-1:0] k;
    priority if (size <= SIZE_W'(8))   k = 3'd0;
    else if (size <= SIZE_W'(16))      k = 3'd1;
    else if (size <= SIZE_W'(32))      k = 3'd2;
    else if (size <= SIZE_W'(64))      k = 3'd3;
    else if (size <= SIZE_W'(128))     k = 3'd4;
    else if (size <= SIZE_W'(256))     k = 3'd5;
    else                               k = 3'd6;
    return k;
  endfunction

  function automatic logic [COPY_W-1:0] class_bytes(input logic [CLASS_W-1:0] k);
    return COPY_W'(COPY_W'(8) << k);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/size_class_block_allocator.sv
// Channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// request  | req_valid, req_stall | req_type, old_addr, old_size, new_size
// response | rsp_valid, rsp_stall | status, new_addr, copy_bytes, old_released
//
// Steps: one request per cycle, while the output register is free, when served
//   by the bump pointer or by a plain free; popping a free list adds a pop
//   step (the link read is registered before the head updates), a resize
//   that allocates and releases adds a give step; a pop and release takes both.
// Reset: rst clears the class heads to empty, the bump pointer to zero and the
//   chunk limit to the end of the first chunk. The link memory is not cleared.
// Stalls: a finished response waits in the output register while the next
//   request is taken; the finishing step waits while that register is full.
`default_nettype none
`include "size_class_block_allocator_macros.svh"

module size_class_block_allocator
  import scba_pkg::*;
#(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int CHUNK_COUNT = CHUNK_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic [1:0]        req_type,
  input  wire logic [ADDR_W-1:0] old_addr,
  input  wire logic [SIZE_W-1:0] old_size,
  input  wire logic [SIZE_W-1:0] new_size,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic [1:0]             status,
  output logic [ADDR_W-1:0]      new_addr,
  output logic [COPY_W-1:0]      copy_bytes,
  output logic                   old_released
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_POP    = 2'd2;
  localparam logic [1:0] ST_GIVE   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Latched request.
  logic [1:0]        req_q;
  logic [ADDR_W-1:0] oaddr_q;
  logic [SIZE_W-1:0] osize_q;
  logic [SIZE_W-1:0] nsize_q;
  logic [ADDR_W-1:0] naddr_q;

  // Class free-list heads: one read port, index chosen per state.
  logic [HEAD_W-1:0]  heads [CLASS_COUNT];
  logic [CLASS_W-1:0] hidx;
  logic [HEAD_W-1:0]  head;

  logic [1:0]         req_eff;
  logic               nbig;
  logic               obig;
  logic [CLASS_W-1:0] kn;
  logic [CLASS_W-1:0] ko;
  logic               take_req;
  logic               give_plain;
  logic               give_on_take;
  logic               pop;
  logic               out_free;
  logic               fin;
  logic               accept;
  logic               pop_now;
  logic               bump_go;

  logic [1:0]        dec_status;
  logic [COPY_W-1:0] dec_copy;

  logic [1:0]        res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [COPY_W-1:0] res_copy;
  logic              res_rel;

  logic              link_we;
  logic              link_re;
  logic [HEAD_W-1:0] link_rdata;

  bump_cmd_t bump_cmd;
  bump_rsp_t bump_rsp;

  // Decode: a resize to zero behaves as a free.
  always_comb begin
    req_eff = (req_q == REQ_RESIZE && nsize_q == '0) ? REQ_FREE : req_q;
    nbig    = nsize_q > SIZE_W'(SMALL_MAX);
    obig    = osize_q > SIZE_W'(SMALL_MAX);
    kn      = class_of(nsize_q);
    ko      = class_of(osize_q);

    take_req     = 1'b0;
    give_plain   = 1'b0;
    give_on_take = 1'b0;
    dec_status   = STAT_DONE;
    dec_copy     = '0;
    unique case (req_eff)
      REQ_ALLOC: begin
        if (nbig) begin
          dec_status = STAT_LARGE;
        end else begin
          take_req = 1'b1;
        end
      end
      REQ_FREE: begin
        if (obig) begin
          dec_status = STAT_LARGE;
        end else begin
          give_plain = 1'b1;
        end
      end
      REQ_RESIZE: begin
        if (obig) begin
          // Old block belongs to the outside allocator: never released here.
          if (nbig) begin
            dec_status = STAT_LARGE;
          end else begin
            take_req = 1'b1;
            dec_copy = nsize_q[COPY_W-1:0];
          end
        end else if (nbig) begin
          dec_status = STAT_LARGE;
          dec_copy   = osize_q[COPY_W-1:0];
          give_plain = 1'b1;
        end else if (kn == ko) begin
          dec_status = STAT_KEPT;
        end else begin
          take_req     = 1'b1;
          give_on_take = 1'b1;
          dec_copy     = (osize_q < nsize_q) ? osize_q[COPY_W-1:0] : nsize_q[COPY_W-1:0];
        end
      end
      default: begin
        // Unknown request: answer done with nothing else.
      end
    endcase
  end

  // Head read: the release class during the give step or when nothing is taken, else the wanted class.
  always_comb begin
    hidx = (state == ST_GIVE) ? ko : (take_req ? kn : ko);
    head = heads[hidx];
    pop  = take_req && (head != EMPTY_MARK);
  end

  assign bump_cmd = '{go: bump_go, cls: kn};

  always_comb begin
    out_free = !rsp_valid || !rsp_stall;

    fin = 1'b0;
    unique case (state)
      ST_DECIDE: fin = out_free && !(take_req && (pop || (bump_rsp.ok && give_on_take)));
      ST_POP:    fin = out_free && !give_on_take;
      ST_GIVE:   fin = out_free;
      default:   fin = 1'b0;
    endcase

    req_stall = !(state == ST_IDLE || fin);
    accept    = req_valid && !req_stall;

    link_re = (state == ST_DECIDE) && pop;
    link_we = fin && ((state == ST_DECIDE && give_plain) || state == ST_GIVE);
    pop_now = (state == ST_POP) && (give_on_take || out_free);
    bump_go = (state == ST_DECIDE) && take_req && !pop &&
              (out_free || (bump_rsp.ok && give_on_take));

    // Result seen when finishing; out of memory only shows in the decide step.
    res_status = dec_status;
    res_copy   = dec_copy;
    res_addr   = '0;
    res_rel    = give_plain || (state == ST_GIVE);
    if (dec_status == STAT_KEPT) begin
      res_addr = oaddr_q;
    end else if (take_req) begin
      if (state == ST_DECIDE && !bump_rsp.ok) begin
        res_status = STAT_OOM;
        res_copy   = '0;
        res_rel    = 1'b0;
      end else if (state == ST_DECIDE) begin
        res_addr = bump_rsp.addr[ADDR_W-1:0];
      end else begin
        res_addr = naddr_q;
      end
    end
  end

  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = ST_DECIDE;
    end else if (fin) begin
      state_next = ST_IDLE;
    end else begin
      unique case (state)
        ST_DECIDE: begin
          if (pop) begin
            state_next = ST_POP;
          end else if (take_req && bump_rsp.ok && give_on_take) begin
            state_next = ST_GIVE;
          end
        end
        ST_POP: begin
          if (give_on_take) begin
            state_next = ST_GIVE;
          end
        end
        default: state_next = state;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request for the whole operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_type;
      oaddr_q <= old_addr;
      osize_q <= old_size;
      nsize_q <= new_size;
    end
    if (state == ST_DECIDE) begin
      naddr_q <= pop ? head[ADDR_W-1:0] : bump_rsp.addr[ADDR_W-1:0];
    end
  end

  // Pop: head takes the link word. Push: head takes the released address.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLASS_COUNT; i++) begin
        heads[i] <= EMPTY_MARK;
      end
    end else begin
      if (pop_now) begin
        heads[kn] <= link_rdata;
      end
      if (link_we) begin
        heads[ko] <= {1'b0, oaddr_q};
      end
    end
  end

  scba_ram #(
    .WIDTH(HEAD_W),
    .DEPTH(LINK_DEPTH)
  ) u_link (
    .clk  (clk),
    .we   (link_we),
    .waddr(oaddr_q[ADDR_W-1:3]),
    .wdata(head),
    .re   (link_re),
    .raddr(head[ADDR_W-1:3]),
    .rdata(link_rdata)
  );

  scba_bump #(
    .CHUNK_BYTES(CHUNK_BYTES),
    .CHUNK_COUNT(CHUNK_COUNT)
  ) u_bump (
    .clk(clk),
    .rst(rst),
    .cmd(bump_cmd),
    .rsp(bump_rsp)
  );

  // Output register: load on finish, drop after transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status       <= res_status;
      new_addr     <= res_addr;
      copy_bytes   <= res_copy;
      old_released <= res_rel;
    end
  end

  `SCBA_ASSERT_IMP(a_link_no_clash, clk, rst, link_re, !link_we, "link read and write collide")
  `SCBA_ASSERT_NXT(a_pop_follows, clk, rst, link_re, state == ST_POP, "pop step missing")
  `SCBA_ASSERT_IMP(a_give_resize, clk, rst, state == ST_GIVE, give_on_take, "bad give step")
  `SCBA_ASSERT_IMP(a_kept_clean, clk, rst, rsp_valid && status == STAT_KEPT,
    copy_bytes == '0 && !old_released, "kept block reports copy or release")

endmodule

`default_nettype wire

// File: rtl/core/scba_ram.sv
`default_nettype none

module scba_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/scba_bump.sv
`default_nettype none

module scba_bump
  import scba_pkg::*;
#(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  parameter int CHUNK_COUNT = CHUNK_COUNT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bump_cmd_t cmd,
  output bump_rsp_t      rsp
);

  // Last usable chunk end: limited by the chunk count and by the address space.
  localparam int TOP_LIMIT = (CHUNK_BYTES * CHUNK_COUNT < ADDR_SPACE) ?
                             CHUNK_BYTES * CHUNK_COUNT : ADDR_SPACE;

  logic [HEAD_W-1:0] bump_addr;
  logic [HEAD_W-1:0] chunk_limit;
  logic [COPY_W-1:0] need;
  logic [HEAD_W-1:0] room;
  logic              fits;
  logic [HEAD_W:0]   limit_next;
  logic              avail;

  always_comb begin
    need       = class_bytes(cmd.cls);
    room       = chunk_limit - bump_addr;
    fits       = room >= HEAD_W'(need);
    limit_next = {1'b0, chunk_limit} + (HEAD_W+1)'(CHUNK_BYTES);
    avail      = limit_next <= (HEAD_W+1)'(TOP_LIMIT);
    rsp.ok     = fits || avail;
    rsp.addr   = fits ? bump_addr : chunk_limit;
  end

  // Carve the block; open the next chunk when the current one is too short.
  always_ff @(posedge clk) begin
    if (rst) begin
      bump_addr   <= '0;
      chunk_limit <= HEAD_W'(CHUNK_BYTES);
    end else if (cmd.go && rsp.ok) begin
      bump_addr <= rsp.addr + HEAD_W'(need);
      if (!fits) begin
        chunk_limit <= limit_next[HEAD_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire
